### hw/rtl/dsep_pkg.sv
// Shared constants, tables and control structs for the date string converter.
package dsep_pkg;

    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int POS_W   = 4;
    localparam int DAYS_W  = 16;
    localparam int MIDX_W  = 4;
    localparam int OFF_W   = 17;
    localparam int SECS_W  = 33;
    localparam int PROD_W  = 33;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DASH = 8'h2d;

    localparam logic [POS_W-1:0] POS_DASH_A = 4'd4;
    localparam logic [POS_W-1:0] POS_DASH_B = 4'd7;
    localparam logic [POS_W-1:0] POS_LAST   = 4'd9;
    localparam logic [POS_W-1:0] DATE_LEN   = 4'd10;

    localparam logic [YEAR_W-1:0] YEAR_LOW  = 14'd1970;
    localparam logic [YEAR_W-1:0] YEAR_HIGH = 14'd2100;
    localparam logic [FIELD_W-1:0] MONTH_HIGH = 7'd12;
    localparam logic [MIDX_W-1:0] FEB_IDX = 4'd1;

    localparam logic [DAYS_W-1:0] YEAR_DAYS  = 16'd365;
    localparam logic [16:0]       SECS_PER_DAY = 17'd86400;
    localparam logic [OFF_W-1:0]  OFFSET_RESET = 17'd28800;

    // Leap rule reduced to the supported year span: 2000 is leap, 2100 is not.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00) && (y != YEAR_HIGH);
    endfunction

    function automatic logic [4:0] month_len(input logic [MIDX_W-1:0] idx);
        logic [4:0] len;
        case (idx)
            4'd1:    len = 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    typedef struct packed {
        logic char_en;
        logic check_en;
        logic year_step;
        logic month_step;
        logic mul_en;
        logic load_out;
    } dsep_cmd_t;

    typedef struct packed {
        logic check_ok;
        logic year_done;
        logic month_done;
        logic out_room;
    } dsep_status_t;

endpackage

### hw/rtl/date_string_to_epoch_seconds_core.sv
// Top level of the YYYY-MM-DD string to epoch-seconds converter.
//
// Characters arrive one per beat on the s_ channel; s_last_char marks the final one,
// which produces exactly one beat on the m_ channel (earlier characters produce none).
// After the final character the block stops taking input while it checks the date,
// adds the days of each year from 1970 to the year before the given one, adds the
// days of each month before the given month, multiplies the day count by the seconds
// per day and hands the result off. The hand-off waits if the previous result has
// not been taken yet. A malformed or out-of-range date skips the summing and goes
// from the check straight to the hand-off with m_date_valid low and m_epoch_seconds
// all ones. The result sits in an output register, so a new string can be fed while
// the previous result waits for m_ready. cfg_wr_data (seconds east of UTC, resets to
// 28800) is subtracted from the local-midnight count; write it only while no string
// is in flight.
module date_string_to_epoch_seconds_core import dsep_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_char_code,
    input  logic                     s_last_char,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_date_valid,
    output logic signed [SECS_W-1:0] m_epoch_seconds,
    input  logic                     cfg_wr_en,
    input  logic signed [OFF_W-1:0]  cfg_wr_data
);

    dsep_cmd_t    cmd;
    dsep_status_t status;

    dsep_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_char (s_last_char),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    dsep_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_char_code     (s_char_code),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .cmd             (cmd),
        .status          (status),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_date_valid    (m_date_valid),
        .m_epoch_seconds (m_epoch_seconds)
    );

endmodule

### hw/rtl/dsep_ctrl.sv
// Sequencer: character intake, date check, day summation, scaling, result hand-off.
module dsep_ctrl import dsep_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_last_char,
    output logic         s_ready,
    input  dsep_status_t status,
    output dsep_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_YEARS  = 3'd2;
    localparam logic [2:0] ST_MONTHS = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.char_en = s_valid;
                if (s_valid && s_last_char) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check_en = 1'b1;
                state_next   = status.check_ok ? ST_YEARS : ST_FIN;
            end
            ST_YEARS: begin
                if (status.year_done) begin
                    state_next = ST_MONTHS;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTHS: begin
                if (status.month_done) begin
                    state_next = ST_MUL;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (status.out_room) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/dsep_datapath.sv
// Field accumulators, date check, day counter, scaling multiply and result register.
module dsep_datapath import dsep_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [7:0]               s_char_code,
    input  logic                     cfg_wr_en,
    input  logic signed [OFF_W-1:0]  cfg_wr_data,
    input  dsep_cmd_t                cmd,
    output dsep_status_t             status,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic                     m_date_valid,
    output logic signed [SECS_W-1:0] m_epoch_seconds
);

    logic [POS_W-1:0]   pos_reg;
    logic               ferr_reg;
    logic               len_ok_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [FIELD_W-1:0] month_reg;
    logic [FIELD_W-1:0] day_reg;
    logic [OFF_W-1:0]   offset_reg;
    logic               ok_reg;
    logic [YEAR_W-1:0]  ycnt_reg;
    logic [MIDX_W-1:0]  midx_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               m_valid_reg;
    logic               date_valid_reg;
    logic [SECS_W-1:0]  epoch_reg;

    logic [POS_W-1:0]   pos_next;
    logic               ferr_next;
    logic [YEAR_W-1:0]  year_next;
    logic [FIELD_W-1:0] month_next;
    logic [FIELD_W-1:0] day_next;
    logic               is_digit;
    logic [3:0]         digit;
    logic [7:0]         char_off;
    logic               y_leap;
    logic [4:0]         mlen;
    logic [SECS_W:0]    secs_wide;

    assign char_off = s_char_code - CHAR_ZERO;
    assign digit    = char_off[3:0];
    assign is_digit = (s_char_code >= CHAR_ZERO) && (s_char_code <= CHAR_NINE);

    // One character beat: position, format flag and decimal fields.
    always_comb begin
        pos_next   = pos_reg;
        ferr_next  = ferr_reg;
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        if (pos_reg >= DATE_LEN) begin
            ferr_next = 1'b1;
        end else if (pos_reg == POS_DASH_A || pos_reg == POS_DASH_B) begin
            if (s_char_code != CHAR_DASH) begin
                ferr_next = 1'b1;
            end
            pos_next = pos_reg + 4'd1;
        end else begin
            if (!is_digit) begin
                ferr_next = 1'b1;
            end else if (pos_reg < POS_DASH_A) begin
                year_next = {year_reg[YEAR_W-4:0], 3'b000} + {year_reg[YEAR_W-2:0], 1'b0}
                          + {{(YEAR_W-4){1'b0}}, digit};
            end else if (pos_reg < POS_DASH_B) begin
                month_next = {month_reg[FIELD_W-4:0], 3'b000}
                           + {month_reg[FIELD_W-2:0], 1'b0} + {3'b000, digit};
            end else begin
                day_next = {day_reg[FIELD_W-4:0], 3'b000}
                         + {day_reg[FIELD_W-2:0], 1'b0} + {3'b000, digit};
            end
            pos_next = pos_reg + 4'd1;
        end
    end

    // Date check; leap and month length only matter once the range test passes.
    assign y_leap = is_leap(year_reg);

    always_comb begin
        mlen = month_len(4'(month_reg - 7'd1));
        if (month_reg == 7'd2 && y_leap) begin
            mlen = 5'd29;
        end
    end

    assign status.check_ok = !ferr_reg && len_ok_reg
                           && (year_reg >= YEAR_LOW) && (year_reg <= YEAR_HIGH)
                           && (month_reg != 7'd0) && (month_reg <= MONTH_HIGH)
                           && (day_reg != 7'd0) && (day_reg <= {2'b00, mlen});
    assign status.year_done  = (ycnt_reg == year_reg);
    assign status.month_done = ({3'b000, midx_reg} + 7'd1 >= month_reg);
    assign status.out_room   = !m_valid_reg || m_ready;

    assign secs_wide = {1'b0, prod_reg} - {{(SECS_W+1-OFF_W){offset_reg[OFF_W-1]}}, offset_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            ferr_reg    <= 1'b0;
            year_reg    <= '0;
            month_reg   <= '0;
            day_reg     <= '0;
            offset_reg  <= OFFSET_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                offset_reg <= cfg_wr_data;
            end
            if (cmd.char_en) begin
                pos_reg   <= pos_next;
                ferr_reg  <= ferr_next;
                year_reg  <= year_next;
                month_reg <= month_next;
                day_reg   <= day_next;
            end else if (cmd.load_out) begin
                pos_reg   <= '0;
                ferr_reg  <= 1'b0;
                year_reg  <= '0;
                month_reg <= '0;
                day_reg   <= '0;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.char_en) begin
            len_ok_reg <= (pos_reg == POS_LAST);
        end
        if (cmd.check_en) begin
            ok_reg   <= status.check_ok;
            ycnt_reg <= YEAR_LOW;
            midx_reg <= '0;
            days_reg <= {{(DAYS_W-FIELD_W){1'b0}}, day_reg} - 16'd1;
        end else if (cmd.year_step) begin
            ycnt_reg <= ycnt_reg + 14'd1;
            days_reg <= days_reg + YEAR_DAYS + {15'd0, is_leap(ycnt_reg)};
        end else if (cmd.month_step) begin
            midx_reg <= midx_reg + 4'd1;
            days_reg <= days_reg + {11'd0, month_len(midx_reg)}
                      + {15'd0, (midx_reg == FEB_IDX) && y_leap};
        end
        if (cmd.mul_en) begin
            prod_reg <= {{(PROD_W-DAYS_W){1'b0}}, days_reg}
                      * {{(PROD_W-17){1'b0}}, SECS_PER_DAY};
        end
        if (cmd.load_out) begin
            date_valid_reg <= ok_reg;
            epoch_reg      <= ok_reg ? secs_wide[SECS_W-1:0] : '1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_date_valid    = date_valid_reg;
    assign m_epoch_seconds = epoch_reg;

    a_load_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before its beat was taken");

    a_invalid_all_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_date_valid) |-> (m_epoch_seconds == '1))
        else $error("invalid result without all-ones seconds");

    a_year_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.year_step |-> (ycnt_reg < year_reg) && (year_reg <= YEAR_HIGH))
        else $error("year counter ran past the target year");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (pos_reg == '0) && !ferr_reg)
        else $error("string state not cleared after a result");

endmodule
